### rtl/ffa_pkg.sv
`default_nettype none
package ffa_pkg;
    localparam logic [1:0] FUNC_ALLOC  = 2'd0;
    localparam logic [1:0] FUNC_TICK   = 2'd1;
    localparam logic [1:0] FUNC_TOG_R  = 2'd2;
    localparam logic [1:0] FUNC_TOG_M  = 2'd3;

    localparam logic [2:0] KIND_PLACED  = 3'd0;
    localparam logic [2:0] KIND_FAILED  = 3'd1;
    localparam logic [2:0] KIND_EVICTED = 3'd2;
    localparam logic [2:0] KIND_DONE    = 3'd3;
    localparam logic [2:0] KIND_ABSENT  = 3'd4;

    localparam int ROW_W = 8 + 16 + 1 + 1;

    typedef struct packed {
        logic [7:0]  owner;
        logic [15:0] size;
        logic        ref_b;
        logic        mod_b;
    } t_row;
endpackage
`default_nettype wire

### rtl/ffa_ram.sv
`default_nettype none
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/first_fit_allocator_nur_eviction.sv
// Channel   | Ports                                          | Direction
// ----------+------------------------------------------------+----------
// command   | i_start, o_busy, i_func, i_proc_id, i_req_size | in
// result    | o_valid, o_kind, o_out_id, o_seg_start,        | out
//           | o_nur_class, o_last                            |
// config    | i_cfg_we, i_cfg_wdata                          | in
// A command is taken when i_start is high and o_busy is low; one item at a time.
// Each table pass reads one row per cycle from the row memory: a toggle makes
// one pass to find the owner, a tick one pass over all residents, and an allocate
// a scan, a shift and a sum pass for each eviction until the request fits or none remain.
// Reset clears the count and the free base; the row memory is not cleared.
// Results last one cycle each and cannot be stalled.
`default_nettype none
module first_fit_allocator_nur_eviction
    import ffa_pkg::*;
#(
    parameter int MAX_SEGMENTS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [1:0]  i_func,
    input  wire logic [7:0]  i_proc_id,
    input  wire logic [15:0] i_req_size,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    output logic             o_valid,
    output logic [2:0]       o_kind,
    output logic [7:0]       o_out_id,
    output logic [15:0]      o_seg_start,
    output logic [1:0]       o_nur_class,
    output logic             o_last
);
    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_EVRD  = 4'd3;
    localparam logic [3:0] S_EVOUT = 4'd4;
    localparam logic [3:0] S_SHIFT = 4'd5;
    localparam logic [3:0] S_SUM   = 4'd6;
    localparam logic [3:0] S_TICK  = 4'd7;
    localparam logic [3:0] S_FIND  = 4'd8;
    localparam logic [3:0] S_TOGW  = 4'd9;

    logic [3:0]  r_state, n_state;
    logic [15:0] r_msize;
    logic [CW-1:0] r_count, n_count;
    logic [15:0] r_free, n_free;
    logic [1:0]  r_func;
    logic [7:0]  r_id;
    logic [15:0] r_size;
    logic [CW-1:0] r_idx, n_idx;
    logic        r_rdv, n_rdv;
    logic [AW-1:0] r_vic, n_vic;
    logic [1:0]  r_vcls, n_vcls;
    logic        r_found, n_found;

    logic        we;
    logic [AW-1:0] waddr, raddr;
    t_row        wrow, rrow;

    ffa_ram #(.WIDTH(ROW_W), .DEPTH(MAX_SEGMENTS)) u_rows (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wrow),
        .i_raddr(raddr), .o_rdata(rrow)
    );

    logic [15:0] room;
    logic        fits;
    logic [CW-1:0] prev;
    logic [1:0]  rcls;

    assign room = (r_msize >= r_free) ? r_msize - r_free : 16'd0;
    assign fits = (r_count < CW'(MAX_SEGMENTS)) && (r_size <= room);
    assign prev = r_idx - CW'(1);
    assign rcls = {rrow.ref_b, rrow.mod_b};
    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state; n_count = r_count; n_free = r_free; n_idx = r_idx;
        n_rdv = 1'b0; n_vic = r_vic; n_vcls = r_vcls; n_found = r_found;
        we = 1'b0; waddr = '0; wrow = rrow; raddr = r_idx[AW-1:0];
        o_valid = 1'b0; o_kind = KIND_DONE; o_out_id = '0; o_seg_start = '0;
        o_nur_class = '0; o_last = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_idx = '0; n_found = 1'b0; n_vcls = 2'd3; n_vic = '0;
                if (r_func == FUNC_ALLOC) begin
                    if (fits) begin
                        we = 1'b1; waddr = r_count[AW-1:0];
                        wrow = '{owner: r_id, size: r_size, ref_b: 1'b1, mod_b: 1'b1};
                        n_count = r_count + CW'(1); n_free = r_free + r_size;
                        o_valid = 1'b1; o_kind = KIND_PLACED; o_out_id = r_id;
                        o_seg_start = r_free; o_last = 1'b1; n_state = S_IDLE;
                    end else if (r_count == '0) begin
                        o_valid = 1'b1; o_kind = KIND_FAILED; o_out_id = r_id;
                        o_last = 1'b1; n_state = S_IDLE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end else if (r_func == FUNC_TICK) begin
                    n_state = S_TICK;
                end else begin
                    n_state = S_FIND;
                end
            end
            S_SCAN: begin
                // Read row r_idx, examine row r_idx-1 when valid.
                if (r_rdv && (!r_found || rcls < r_vcls)) begin
                    n_found = 1'b1; n_vcls = rcls; n_vic = prev[AW-1:0];
                end
                if (r_idx == r_count) begin
                    n_state = S_EVRD;
                end else begin
                    n_idx = r_idx + CW'(1); n_rdv = 1'b1;
                end
            end
            S_EVRD: begin
                raddr = r_vic; n_state = S_EVOUT;
            end
            S_EVOUT: begin
                o_valid = 1'b1; o_kind = KIND_EVICTED; o_out_id = rrow.owner;
                o_nur_class = rcls;
                n_idx = CW'(r_vic) + CW'(1);
                raddr = n_idx[AW-1:0];
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                // Row r_idx is being read; copy it down into r_idx-1.
                if (r_idx >= r_count) begin
                    n_count = r_count - CW'(1); n_idx = '0; n_free = '0;
                    n_state = S_SUM;
                end else begin
                    we = 1'b1; waddr = prev[AW-1:0]; wrow = rrow;
                    n_idx = r_idx + CW'(1); raddr = n_idx[AW-1:0];
                end
            end
            S_SUM: begin
                if (r_rdv) begin
                    n_free = r_free + rrow.size;
                end
                if (r_idx == r_count) begin
                    n_state = S_DEC;
                end else begin
                    n_idx = r_idx + CW'(1); n_rdv = 1'b1;
                end
            end
            S_TICK: begin
                if (r_rdv) begin
                    we = 1'b1; waddr = prev[AW-1:0];
                    wrow = '{owner: rrow.owner, size: rrow.size,
                             ref_b: ~rrow.ref_b, mod_b: ~rrow.mod_b};
                end
                if (r_idx == r_count) begin
                    o_valid = 1'b1; o_kind = KIND_DONE; o_last = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + CW'(1); n_rdv = 1'b1;
                end
            end
            S_FIND: begin
                if (r_rdv && rrow.owner == r_id) begin
                    n_vic = prev[AW-1:0]; raddr = prev[AW-1:0];
                    n_state = S_TOGW;
                end else if (r_idx == r_count) begin
                    o_valid = 1'b1; o_kind = KIND_ABSENT; o_out_id = r_id;
                    o_last = 1'b1; n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + CW'(1); n_rdv = 1'b1;
                end
            end
            S_TOGW: begin
                we = 1'b1; waddr = r_vic; wrow = rrow;
                if (r_func == FUNC_TOG_R) begin
                    wrow.ref_b = ~rrow.ref_b;
                end else begin
                    wrow.mod_b = ~rrow.mod_b;
                end
                o_valid = 1'b1; o_kind = KIND_DONE; o_out_id = r_id;
                o_nur_class = {wrow.ref_b, wrow.mod_b}; o_last = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_count <= '0; r_free <= '0; r_msize <= 16'd1024;
            r_rdv <= 1'b0; r_found <= 1'b0;
        end else begin
            r_state <= n_state; r_count <= n_count; r_free <= n_free;
            r_rdv <= n_rdv; r_found <= n_found;
            if (i_cfg_we) begin
                r_msize <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx; r_vic <= n_vic; r_vcls <= n_vcls;
        if (r_state == S_IDLE && i_start) begin
            r_func <= i_func; r_id <= i_proc_id; r_size <= i_req_size;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SEGMENTS)) else $error("resident count overflow");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> (r_state == S_IDLE)) else $error("busy after last");
    a_evict_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (o_kind == KIND_EVICTED)) else $error("bad non-last");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_valid) else $error("result while idle");
endmodule
`default_nettype wire
